@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the pressure compensation design.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, clk, rst, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

@@ design/baro_pc_pkg.sv @@
// ----------------------------------------------------------------------------
// Barometric compensation package
// Shared types and constants of the pressure compensation pipeline.
// ----------------------------------------------------------------------------
package baro_pc_pkg;

  localparam int CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] REG_SENS       = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_OFF        = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SENS_TEMP  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_OFF_TEMP   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_REF_TEMP   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_TEMP_SLOPE = 3'd5;

  localparam logic signed [18:0] TEMP_BASE    = 19'sd2000;
  localparam logic signed [17:0] TEMP_LOW_OFS = -18'sd3500;
  localparam logic signed [18:0] TEMP_LOW_ADJ = 19'sd3500;

  typedef struct packed {
    logic [15:0] sens;
    logic [15:0] off;
    logic [15:0] sens_temp;
    logic [15:0] off_temp;
    logic [15:0] ref_temp;
    logic [15:0] temp_slope;
  } cal_t;

  typedef struct packed {
    logic [23:0]        d1;
    logic signed [17:0] dtemp;
    logic signed [18:0] temp;
    logic signed [35:0] off;
    logic signed [34:0] sens;
    logic [17:0]        t2;
    logic               lt0;
    logic               lt1;
  } lin_t;

  typedef struct packed {
    logic [23:0]        d1;
    logic signed [41:0] off_c;
    logic signed [41:0] sens_c;
    logic signed [19:0] temp_c;
  } comp_t;

endpackage

@@ design/baro_pc_front.sv @@
// ----------------------------------------------------------------------------
// Linear terms
// Computes dT, its products with the calibration words, and the first-order
// temperature, offset and sensitivity over three register stages.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module baro_pc_front (
  input  logic               clk,
  input  logic               rst,
  input  baro_pc_pkg::cal_t  cal,
  input  logic               in_valid,
  input  logic [23:0]        d1_in,
  input  logic [23:0]        d2_in,
  output logic               lin_valid,
  output baro_pc_pkg::lin_t  lin
);
  import baro_pc_pkg::*;

  logic               s1_valid;
  logic [23:0]        s1_d1;
  logic signed [24:0] s1_dt;

  logic               s2_valid;
  logic [23:0]        s2_d1;
  logic signed [41:0] s2_pt;
  logic signed [41:0] s2_po;
  logic signed [41:0] s2_ps;
  logic signed [49:0] s2_pq;

  logic               s3_valid;
  lin_t               s3;
  lin_t               s3_next;

  always_comb begin
    s3_next.d1    = s2_d1;
    s3_next.dtemp = $signed(s2_pt[40:23]);
    s3_next.temp  = $signed({s3_next.dtemp[17], s3_next.dtemp}) + TEMP_BASE;
    s3_next.off   = $signed({4'b0, cal.off, 16'h0000}) + 36'(s2_po >>> 7);
    s3_next.sens  = $signed({4'b0, cal.sens, 15'h0000}) + 35'(s2_ps >>> 8);
    s3_next.t2    = s2_pq[48:31];
    s3_next.lt0   = s3_next.dtemp[17];
    s3_next.lt1   = (s3_next.dtemp < TEMP_LOW_OFS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_d1 <= d1_in;
    s1_dt <= $signed({1'b0, d2_in}) - $signed({1'b0, cal.ref_temp, 8'h00});
    s2_d1 <= s1_d1;
    s2_pt <= s1_dt * $signed({1'b0, cal.temp_slope});
    s2_po <= s1_dt * $signed({1'b0, cal.off_temp});
    s2_ps <= s1_dt * $signed({1'b0, cal.sens_temp});
    s2_pq <= s1_dt * s1_dt;
    s3    <= s3_next;
  end

  assign lin_valid = s3_valid;
  assign lin       = s3;

  `ASSERT_CLK(a_cold_band_nested, clk, rst, (s3_valid && s3.lt1) |-> s3.lt0)

endmodule

@@ design/baro_pc_corr.sv @@
// ----------------------------------------------------------------------------
// Second-order correction
// Squares the temperature deviations, forms OFF2 and SENS2 for the cold
// bands, and applies T2, OFF2 and SENS2 to temperature, offset and sensitivity.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module baro_pc_corr (
  input  logic               clk,
  input  logic               rst,
  input  logic               lin_valid,
  input  baro_pc_pkg::lin_t  lin,
  output logic               comp_valid,
  output baro_pc_pkg::comp_t comp
);
  import baro_pc_pkg::*;

  logic signed [18:0] xb;
  logic signed [35:0] sq_a;
  logic signed [37:0] sq_b;

  logic               s4_valid;
  lin_t               s4;
  logic [34:0]        s4_a;
  logic [34:0]        s4_b;

  logic [39:0]        a5;
  logic [39:0]        b7;
  logic [39:0]        b11;
  logic [39:0]        off2_next;
  logic [39:0]        sens2_next;

  logic               s5_valid;
  logic [23:0]        s5_d1;
  logic signed [35:0] s5_off;
  logic signed [34:0] s5_sens;
  logic signed [19:0] s5_temp;
  logic [39:0]        s5_off2;
  logic [39:0]        s5_sens2;

  logic               s6_valid;
  comp_t              s6;

  always_comb begin
    xb   = $signed({lin.dtemp[17], lin.dtemp}) + TEMP_LOW_ADJ;
    sq_a = lin.dtemp * lin.dtemp;
    sq_b = xb * xb;
  end

  always_comb begin
    a5  = {5'b0, s4_a} + {3'b0, s4_a, 2'b00};
    b7  = {2'b0, s4_b, 3'b000} - {5'b0, s4_b};
    b11 = {2'b0, s4_b, 3'b000} + {4'b0, s4_b, 1'b0} + {5'b0, s4_b};
    off2_next  = '0;
    sens2_next = '0;
    if (s4.lt0) begin
      off2_next  = {1'b0, a5[39:1]};
      sens2_next = {2'b0, a5[39:2]};
      if (s4.lt1) begin
        off2_next  = off2_next + b7;
        sens2_next = sens2_next + {1'b0, b11[39:1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      s6_valid <= 1'b0;
    end else begin
      s4_valid <= lin_valid;
      s5_valid <= s4_valid;
      s6_valid <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    s4       <= lin;
    s4_a     <= sq_a[34:0];
    s4_b     <= sq_b[34:0];
    s5_d1    <= s4.d1;
    s5_off   <= s4.off;
    s5_sens  <= s4.sens;
    s5_temp  <= s4.lt0 ? (20'(s4.temp) - $signed({2'b00, s4.t2})) : 20'(s4.temp);
    s5_off2  <= off2_next;
    s5_sens2 <= sens2_next;
    s6.d1     <= s5_d1;
    s6.off_c  <= 42'(s5_off) - $signed({2'b00, s5_off2});
    s6.sens_c <= 42'(s5_sens) - $signed({2'b00, s5_sens2});
    s6.temp_c <= s5_temp;
  end

  assign comp_valid = s6_valid;
  assign comp       = s6;

  `ASSERT_CLK(a_warm_no_corr, clk, rst, (s4_valid && !s4.lt0) |=> ((s5_off2 | s5_sens2) == '0))

endmodule

@@ design/baro_pc_press.sv @@
// ----------------------------------------------------------------------------
// Pressure output stage
// Multiplies the raw pressure by the corrected sensitivity in two partial
// products, removes the offset, and saturates both results.
// ----------------------------------------------------------------------------
module baro_pc_press (
  input  logic               clk,
  input  logic               rst,
  input  logic               comp_valid,
  input  baro_pc_pkg::comp_t comp,
  output logic               out_valid,
  output logic [23:0]        pressure,
  output logic signed [15:0] temperature
);
  import baro_pc_pkg::*;

  logic               s7_valid;
  logic [44:0]        s7_pp_lo;
  logic signed [45:0] s7_pp_hi;
  logic signed [41:0] s7_off;
  logic signed [19:0] s7_temp;

  logic               s8_valid;
  logic signed [66:0] s8_sum;
  logic signed [41:0] s8_off;
  logic signed [19:0] s8_temp;

  logic               s9_valid;
  logic signed [46:0] s9_x;
  logic signed [19:0] s9_temp;

  logic [23:0]        pressure_next;
  logic signed [15:0] temperature_next;

  always_comb begin
    if (s9_x[46]) begin
      pressure_next = '0;
    end else if (s9_x[45:39] != 7'd0) begin
      pressure_next = '1;
    end else begin
      pressure_next = s9_x[38:15];
    end
    if (s9_temp[19] && (s9_temp[18:15] != 4'hF)) begin
      temperature_next = 16'sh8000;
    end else if (!s9_temp[19] && (s9_temp[18:15] != 4'h0)) begin
      temperature_next = 16'sh7FFF;
    end else begin
      temperature_next = s9_temp[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_valid  <= 1'b0;
      s8_valid  <= 1'b0;
      s9_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s7_valid  <= comp_valid;
      s8_valid  <= s7_valid;
      s9_valid  <= s8_valid;
      out_valid <= s9_valid;
    end
  end

  always_ff @(posedge clk) begin
    s7_pp_lo    <= {21'b0, comp.d1} * {24'b0, comp.sens_c[20:0]};
    s7_pp_hi    <= $signed({1'b0, comp.d1}) * $signed(comp.sens_c[41:21]);
    s7_off      <= comp.off_c;
    s7_temp     <= comp.temp_c;
    s8_sum      <= $signed({s7_pp_hi, 21'b0}) + $signed({22'b0, s7_pp_lo});
    s8_off      <= s7_off;
    s8_temp     <= s7_temp;
    s9_x        <= $signed({s8_sum[66], s8_sum[66:21]}) - 47'(s8_off);
    s9_temp     <= s8_temp;
    pressure    <= pressure_next;
    temperature <= temperature_next;
  end

endmodule

@@ design/baro_pressure_compensation.sv @@
// ----------------------------------------------------------------------------
// Barometric pressure compensation
// Second-order compensation of raw pressure and temperature conversions.
// ----------------------------------------------------------------------------
// Usage:
// Load the six calibration words through the configuration channel
// (cfg_valid, cfg_ready, cfg_index, cfg_data) while no sample is in flight;
// cfg_ready is always high and indexes above five are ignored.
// A sample pair is taken on every clock edge where start is high and busy is
// low; busy is never raised, so one transfer per cycle is sustained.
// Each sample gives one result: pressure in 0.01 mbar and temperature in
// 0.01 C appear on the ports together with a one-cycle result_valid strobe
// after passing the ten register stages. The ten register stages are three
// for the linear terms, three for the second-order correction and four for
// the pressure product, offset removal and saturation.
// Results cannot be held off; the receiver must take each strobe.
// Synchronous reset clears the calibration words to zero and drops every
// sample in flight.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module baro_pressure_compensation (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [23:0]                        pressure_raw,
  input  logic [23:0]                        temp_raw,
  output logic                               result_valid,
  output logic [23:0]                        pressure,
  output logic signed [15:0]                 temperature,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [baro_pc_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [15:0]                        cfg_data
);
  import baro_pc_pkg::*;

  cal_t  cal;
  logic  lin_valid;
  lin_t  lin;
  logic  comp_valid;
  comp_t comp;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SENS:       cal.sens       <= cfg_data;
        REG_OFF:        cal.off        <= cfg_data;
        REG_SENS_TEMP:  cal.sens_temp  <= cfg_data;
        REG_OFF_TEMP:   cal.off_temp   <= cfg_data;
        REG_REF_TEMP:   cal.ref_temp   <= cfg_data;
        REG_TEMP_SLOPE: cal.temp_slope <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  baro_pc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cal       (cal),
    .in_valid  (start && !busy),
    .d1_in     (pressure_raw),
    .d2_in     (temp_raw),
    .lin_valid (lin_valid),
    .lin       (lin)
  );

  baro_pc_corr u_corr (
    .clk        (clk),
    .rst        (rst),
    .lin_valid  (lin_valid),
    .lin        (lin),
    .comp_valid (comp_valid),
    .comp       (comp)
  );

  baro_pc_press u_press (
    .clk         (clk),
    .rst         (rst),
    .comp_valid  (comp_valid),
    .comp        (comp),
    .out_valid   (result_valid),
    .pressure    (pressure),
    .temperature (temperature)
  );

  `ASSERT_CLK(a_latency_fwd, clk, rst, (start && !busy) |-> ##10 result_valid)
  `ASSERT_CLK(a_latency_rev, clk, rst, result_valid |-> $past(start && !busy, 10))
  `ASSERT_ALWAYS(a_reset_flush, clk, $past(rst) |-> !result_valid)

endmodule
